// ===== hw/rtl/motor_power_limit_scale_assert.svh =====
// Assertion macros for the motor power limit scaling block
`ifndef MOTOR_POWER_LIMIT_SCALE_ASSERT_SVH
`define MOTOR_POWER_LIMIT_SCALE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define MPLS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define MPLS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/mpls_pkg.sv =====
// Constants for the motor power limit scaling block
package mpls_pkg;
  localparam int MOTOR_COUNT_DEF = 4;
  localparam int CUR_W = 16;
  localparam int SPD_W = 15;
  localparam int VOLT_W = 12;
  localparam int ALLOW_W = 10;
  localparam int SCALE_W = 16;
  localparam int EST_W = 16;
  localparam int MAG_W = 48;
  localparam int NUM_W = 48;
  localparam int QBITS = 16;

  localparam int CFG_ADDR_W = 5;
  localparam logic [2:0] REG_TORQUE = 3'd0;
  localparam logic [2:0] REG_SPEED_SQ = 3'd1;
  localparam logic [2:0] REG_CURR_SQ = 3'd2;
  localparam logic [2:0] REG_STATIC = 3'd3;
  localparam logic [2:0] REG_MARGIN = 3'd4;

  localparam logic [15:0] TORQUE_RST = 16'd8577;
  localparam logic [15:0] SPEED_SQ_RST = 16'd2857;
  localparam logic [15:0] CURR_SQ_RST = 16'd528;
  localparam logic [23:0] STATIC_RST = 24'd267452;
  localparam logic [15:0] MARGIN_RST = 16'd33;

  localparam logic [VOLT_W-1:0] VOLT_KNEE = 12'd500;
  localparam logic [15:0] EST_RECIP = 16'd61680;   // floor(2^20 / 17)
  localparam int EST_SAT = 1114112;                // 65536 * 17
  localparam logic [SCALE_W-1:0] SCALE_ONE = 16'd32768;
endpackage

// ===== hw/rtl/motor_power_limit_scale.sv =====
// Motor power limit scaling: power estimate, budget and drive scale pipeline
// Stage order: products, coefficients, magnitude, total, setup, divider, output.
// Throughput: one item per cycle unless stalled; depth is one compare-subtract of
// the 16-step pipelined restoring divider for the budget/estimate ratio.
// A stalled output freezes the whole pipeline; nothing is lost or repeated.
// Reset: synchronous, active low; clears valid bits and loads register defaults.
`include "motor_power_limit_scale_assert.svh"
module motor_power_limit_scale #(
  parameter int MOTOR_COUNT = mpls_pkg::MOTOR_COUNT_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // currents (16b each), speeds (15b each), cap_voltage, allowed_power, zero fill
  input  logic [((31*MOTOR_COUNT+22+7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // drive_scale [15:0], estimated_power [31:16]
  output logic [31:0] out_tdata,
  input  logic cfg_psel,
  input  logic cfg_penable,
  input  logic cfg_pwrite,
  input  logic [mpls_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic cfg_pready
);
  import mpls_pkg::*;

  localparam int SUM_W = MAG_W + $clog2(MOTOR_COUNT);
  localparam int D_W = SUM_W + 5;
  localparam int REM_W = D_W + 1;
  localparam int SPD_BASE = CUR_W * MOTOR_COUNT;
  localparam int VOLT_BASE = SPD_BASE + SPD_W * MOTOR_COUNT;
  localparam int ALLOW_BASE = VOLT_BASE + VOLT_W;

  // ---------------- configuration registers
  logic [15:0] torque_r, speed_sq_r, curr_sq_r, margin_r;
  logic [23:0] static_r;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_idx = cfg_paddr[4:2];
  assign cfg_wr = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      torque_r <= TORQUE_RST;
      speed_sq_r <= SPEED_SQ_RST;
      curr_sq_r <= CURR_SQ_RST;
      static_r <= STATIC_RST;
      margin_r <= MARGIN_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_TORQUE:   torque_r <= cfg_pwdata[15:0];
        REG_SPEED_SQ: speed_sq_r <= cfg_pwdata[15:0];
        REG_CURR_SQ:  curr_sq_r <= cfg_pwdata[15:0];
        REG_STATIC:   static_r <= cfg_pwdata[23:0];
        REG_MARGIN:   margin_r <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_TORQUE:   cfg_prdata = {16'd0, torque_r};
      REG_SPEED_SQ: cfg_prdata = {16'd0, speed_sq_r};
      REG_CURR_SQ:  cfg_prdata = {16'd0, curr_sq_r};
      REG_STATIC:   cfg_prdata = {8'd0, static_r};
      REG_MARGIN:   cfg_prdata = {16'd0, margin_r};
      default:      cfg_prdata = 32'd0;
    endcase
  end

  // ---------------- pipeline control
  logic en;
  logic v1_r, v2_r, v3_r, v4_r, v5_r, vo_r;
  logic dv_r [QBITS];

  assign en = !vo_r | out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0; v5_r <= 1'b0;
      vo_r <= 1'b0;
      for (int d = 0; d < QBITS; d++) dv_r[d] <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r; v3_r <= v2_r; v4_r <= v3_r; v5_r <= v4_r;
      dv_r[0] <= v5_r;
      for (int d = 1; d < QBITS; d++) dv_r[d] <= dv_r[d-1];
      vo_r <= dv_r[QBITS-1];
    end
  end

  // ---------------- stage 1: raw products, budget
  logic signed [30:0] ci_r [MOTOR_COUNT];
  logic [28:0]        ss_r [MOTOR_COUNT];
  logic [30:0]        cc_r [MOTOR_COUNT];
  logic signed [16:0] bud_nxt;
  logic               bpos1_r, bpos2_r, bpos3_r, bpos4_r;
  logic [14:0]        b1_r, b2_r, b3_r, b4_r;
  logic [VOLT_W-1:0]  volt;
  logic [ALLOW_W-1:0] allow;

  assign volt = in_tdata[VOLT_BASE +: VOLT_W];
  assign allow = in_tdata[ALLOW_BASE +: ALLOW_W];

  always_comb begin
    if (volt <= VOLT_KNEE)
      bud_nxt = $signed({3'b0, allow, 4'b0}) - 17'sd32;
    else
      bud_nxt = $signed({3'b0, allow, 4'b0}) + $signed({4'b0, volt, 1'b0});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int m = 0; m < MOTOR_COUNT; m++) begin
        logic signed [CUR_W-1:0] c;
        logic signed [SPD_W-1:0] s;
        logic signed [31:0] c2;
        logic signed [29:0] s2;
        c = in_tdata[CUR_W*m +: CUR_W];
        s = in_tdata[SPD_BASE + SPD_W*m +: SPD_W];
        c2 = c * c;
        s2 = s * s;
        ci_r[m] <= c * s;
        ss_r[m] <= s2[28:0];
        cc_r[m] <= c2[30:0];
      end
      bpos1_r <= (bud_nxt > 17'sd0);
      b1_r <= bud_nxt[14:0];
    end
  end

  // ---------------- stage 2: coefficient products
  logic signed [47:0] tp_r [MOTOR_COUNT];
  logic [44:0]        kp_r [MOTOR_COUNT];
  logic [46:0]        ap_r [MOTOR_COUNT];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int m = 0; m < MOTOR_COUNT; m++) begin
        tp_r[m] <= $signed({1'b0, torque_r}) * ci_r[m];
        kp_r[m] <= speed_sq_r * ss_r[m];
        ap_r[m] <= curr_sq_r * cc_r[m];
      end
      bpos2_r <= bpos1_r;
      b2_r <= b1_r;
    end
  end

  // ---------------- stage 3: per-motor power magnitude
  logic [MAG_W-1:0] mag_r [MOTOR_COUNT];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int m = 0; m < MOTOR_COUNT; m++) begin
        logic signed [48:0] p;
        p = 49'(tp_r[m]) + $signed({4'b0, kp_r[m]}) + $signed({2'b0, ap_r[m]})
          + $signed({9'b0, static_r, 16'b0});
        mag_r[m] <= p[48] ? MAG_W'(-p) : p[MAG_W-1:0];
      end
      bpos3_r <= bpos2_r;
      b3_r <= b2_r;
    end
  end

  // ---------------- stage 4: total
  logic [SUM_W-1:0] tot_r;
  logic [SUM_W-1:0] tot_nxt;

  always_comb begin
    tot_nxt = '0;
    for (int m = 0; m < MOTOR_COUNT; m++) tot_nxt = tot_nxt + SUM_W'(mag_r[m]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tot_r <= tot_nxt;
      bpos4_r <= bpos3_r;
      b4_r <= b3_r;
    end
  end

  // ---------------- stage 5: denominator, numerator, flags, estimate index
  logic [D_W-1:0]   den_nxt, den5_r;
  logic [NUM_W-1:0] num_nxt, num5_r;
  logic [19:0]      b17;
  logic [D_W-29:0]  xq;
  logic             bpos5_r, tz5_r, cap5_r, sat5_r;
  logic [20:0]      xc5_r;

  assign den_nxt = D_W'({tot_r, 4'b0}) + D_W'({tot_r, 2'b0});
  assign b17 = {1'b0, b4_r, 4'b0} + 20'(b4_r);
  assign num_nxt = {b17, 28'b0};
  assign xq = den_nxt[D_W-1:28];

  always_ff @(posedge clk) begin
    if (en) begin
      den5_r <= den_nxt;
      num5_r <= num_nxt;
      bpos5_r <= bpos4_r;
      tz5_r <= (tot_r == '0);
      cap5_r <= (D_W'(num_nxt) > den_nxt);
      sat5_r <= (xq >= (D_W-28)'(EST_SAT));
      xc5_r <= xq[20:0];
    end
  end

  // ---------------- divider stages, one quotient bit each, msb first
  logic [REM_W-1:0]   rem_r [QBITS];
  logic [D_W-1:0]     den_r [QBITS];
  logic [QBITS-1:0]   q_r [QBITS];
  logic               bpos_r [QBITS];
  logic               tz_r [QBITS];
  logic               cap_r [QBITS];
  logic [EST_W-1:0]   est_r [QBITS];
  logic [36:0]        estp_r;
  logic               sat6_r;
  logic [20:0]        xc6_r;

  // estimate: floor(x / 17) by reciprocal with one upward correction, saturating to all ones
  logic [15:0] q0;
  logic [21:0] er;
  logic [EST_W-1:0] est_nxt;

  assign q0 = estp_r[35:20];
  assign er = {1'b0, xc6_r} - ({2'b0, q0, 4'b0} + 22'(q0));

  always_comb begin
    if (sat6_r)
      est_nxt = '1;
    else if (er >= 22'd17)
      est_nxt = q0 + 16'd1;
    else
      est_nxt = q0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      estp_r <= xc5_r * EST_RECIP;
      sat6_r <= sat5_r;
      xc6_r <= xc5_r;
    end
  end

  for (genvar g = 0; g < QBITS; g++) begin : g_div
    logic [REM_W-1:0] src, trial;
    logic [D_W-1:0]   dsrc;
    logic [QBITS-1:0] qsrc;
    logic             ge;
    if (g == 0) begin : g_first
      assign src = REM_W'(num5_r);
      assign dsrc = den5_r;
      assign qsrc = '0;

      always_ff @(posedge clk) begin
        if (en) begin
          bpos_r[g] <= bpos5_r;
          tz_r[g] <= tz5_r;
          cap_r[g] <= cap5_r;
          est_r[g] <= '0;
        end
      end
    end else begin : g_rest
      assign src = {rem_r[g-1][REM_W-2:0], 1'b0};
      assign dsrc = den_r[g-1];
      assign qsrc = q_r[g-1];

      always_ff @(posedge clk) begin
        if (en) begin
          bpos_r[g] <= bpos_r[g-1];
          tz_r[g] <= tz_r[g-1];
          cap_r[g] <= cap_r[g-1];
          est_r[g] <= (g == 1) ? est_nxt : est_r[g-1];
        end
      end
    end
    assign trial = src - REM_W'(dsrc);
    assign ge = (src >= REM_W'(dsrc));

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g] <= ge ? trial : src;
        den_r[g] <= dsrc;
        q_r[g] <= qsrc | (QBITS'(ge) << (QBITS-1-g));
      end
    end
  end

  // ---------------- output stage
  logic [SCALE_W-1:0] scale_nxt, scale_r;
  logic [EST_W-1:0]   esto_r;
  logic [QBITS-1:0]   qf;

  assign qf = q_r[QBITS-1];

  always_comb begin
    if (!bpos_r[QBITS-1])
      scale_nxt = '0;
    else if (tz_r[QBITS-1] || cap_r[QBITS-1])
      scale_nxt = SCALE_ONE;
    else if (qf > margin_r)
      scale_nxt = qf - margin_r;
    else
      scale_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      scale_r <= scale_nxt;
      esto_r <= est_r[QBITS-1];
    end
  end

  assign out_tvalid = vo_r;
  assign out_tdata = {esto_r, scale_r};

  `MPLS_ASSERT_NOW(a_scale_range, out_tvalid, out_tdata[15:0] <= SCALE_ONE, "scale above one")
  `MPLS_ASSERT_NOW(a_stall_blocks, out_tvalid && !out_tready, !in_tready, "input taken during stall")
  `MPLS_ASSERT_NEXT(a_enter, in_tvalid && in_tready, v1_r, "accepted item lost at entry")
  `MPLS_ASSERT_NEXT(a_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result changed while stalled")
endmodule

// ===== tb/motor_power_limit_scale_test.sv =====
// Self-checking testbench for the motor power limit scaling block
`timescale 1ns / 1ps
module motor_power_limit_scale_test;
  import mpls_pkg::*;

  localparam int MOTORS = 4;
  localparam int IN_W = ((31*MOTORS+22+7)/8)*8;
  localparam int DRAIN_CYCLES = 40;
  localparam int STALL_LIMIT = 20000;

  typedef struct {
    logic signed [CUR_W-1:0] cur [MOTORS];
    logic signed [SPD_W-1:0] spd [MOTORS];
    logic [VOLT_W-1:0] volt;
    logic [ALLOW_W-1:0] allow;
  } drive_item_t;

  typedef struct {
    logic [SCALE_W-1:0] scale;
    logic [EST_W-1:0] est;
  } scale_result_t;

  // Holds the register copy, computes each item's scale and estimate and checks results in order.
  class power_scoreboard;
    longint torque, speed_sq, curr_sq, static_w, margin;
    scale_result_t pending[$];
    int errors;

    function void load_defaults();
      torque = TORQUE_RST;
      speed_sq = SPEED_SQ_RST;
      curr_sq = CURR_SQ_RST;
      static_w = STATIC_RST;
      margin = MARGIN_RST;
      errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        REG_TORQUE: torque = val[15:0];
        REG_SPEED_SQ: speed_sq = val[15:0];
        REG_CURR_SQ: curr_sq = val[15:0];
        REG_STATIC: static_w = val[23:0];
        REG_MARGIN: margin = val[15:0];
        default: ;
      endcase
    endfunction

    function void note_input(drive_item_t it);
      longint unsigned total, est, b, den, r;
      longint c, s, p, budget;
      scale_result_t res;
      total = 0;
      for (int i = 0; i < MOTORS; i++) begin
        c = it.cur[i];
        s = it.spd[i];
        p = torque*c*s + speed_sq*s*s + curr_sq*c*c + (static_w <<< 16);
        total += (p < 0) ? longint'(-p) : longint'(p);
      end
      est = (total * 20) / 17;
      est = est >> 28;
      res.est = (est > 65535) ? 16'hFFFF : est[15:0];
      if (it.volt <= VOLT_KNEE)
        budget = longint'(it.allow) * 16 - 32;
      else
        budget = longint'(it.allow) * 16 + 2 * longint'(it.volt);
      if (budget <= 0) begin
        res.scale = '0;
      end else if (total == 0) begin
        res.scale = SCALE_ONE;
      end else begin
        b = budget;
        den = total * 20;
        if (b * 17 * (64'd1 << 28) > den) begin
          res.scale = SCALE_ONE;
        end else begin
          r = (b * 17 * (64'd1 << 43)) / den;
          res.scale = (r > margin) ? 16'(r - margin) : '0;
        end
      end
      pending.push_back(res);
    endfunction

    function void check_result(logic [31:0] data);
      scale_result_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result transfer, actual %h", $time, data);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (data[15:0] !== want.scale) begin
        $display("%0t: drive_scale expected %0d actual %0d", $time, want.scale, data[15:0]);
        errors++;
      end
      if (data[31:16] !== want.est) begin
        $display("%0t: estimated_power expected %0d actual %0d", $time, want.est,
                 data[31:16]);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [31:0] out_tdata;
  logic cfg_psel = 0, cfg_penable = 0, cfg_pwrite = 0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  power_scoreboard board = new();
  bit calm = 0;       // no idling on either side
  bit hold_req = 0;   // receiver holds off for a long stretch
  int idle_cycles = 0;

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  motor_power_limit_scale DUT (.*);

  // result side: random backpressure plus one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 0;
    end else if (hold_req) begin
      out_tready <= 0;
      repeat (300) @(posedge clk);
      hold_req = 0;
    end else begin
      out_tready <= calm || ($urandom_range(99) >= 9);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_result(out_tdata);
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("motor_power_limit_scale_test: FAIL");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_psel <= 1;
    cfg_penable <= 0;
    cfg_pwrite <= 1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    cfg_psel <= 0;
    cfg_penable <= 0;
    cfg_pwrite <= 0;
    board.set_reg(idx, val);
  endtask

  task automatic write_all(logic [31:0] tq, logic [31:0] sq, logic [31:0] cq,
                           logic [31:0] st, logic [31:0] mg);
    write_reg(REG_TORQUE, tq);
    write_reg(REG_SPEED_SQ, sq);
    write_reg(REG_CURR_SQ, cq);
    write_reg(REG_STATIC, st);
    write_reg(REG_MARGIN, mg);
  endtask

  task automatic send(drive_item_t it);
    logic [IN_W-1:0] d;
    while (!calm && $urandom_range(99) < 9) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    d = '0;
    for (int i = 0; i < MOTORS; i++) begin
      d[16*i +: 16] = it.cur[i];
      d[64 + 15*i +: 15] = it.spd[i];
    end
    d[124 +: 12] = it.volt;
    d[136 +: 10] = it.allow;
    in_tdata <= d;
    in_tvalid <= 1;
    do @(posedge clk); while (!in_tready);
    board.note_input(it);
  endtask

  // sender pauses until every result is back, then lets the pipeline settle
  task automatic drain();
    in_tvalid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic drive_item_t uniform(int c, int s, int v, int a);
    drive_item_t it;
    for (int i = 0; i < MOTORS; i++) begin
      it.cur[i] = c;
      it.spd[i] = s;
    end
    it.volt = v;
    it.allow = a;
    return it;
  endfunction

  function automatic drive_item_t random_item();
    drive_item_t it;
    int lc, ls;
    for (int i = 0; i < MOTORS; i++) begin
      case ($urandom_range(3))
        0: begin lc = 50; ls = 50; end
        1: begin lc = 2000; ls = 1500; end
        2: begin lc = 8000; ls = 9000; end
        default: begin lc = 16384; ls = 16384; end
      endcase
      it.cur[i] = int'($urandom_range(2*lc)) - lc;
      it.spd[i] = (ls == 16384) ? int'($urandom_range(32767)) - 16384
                                : int'($urandom_range(2*ls)) - ls;
    end
    it.volt = ($urandom_range(3) == 0) ? $urandom_range(490, 510) : $urandom_range(3000);
    it.allow = $urandom_range(1023);
    return it;
  endfunction

  task automatic random_run(int n);
    repeat (n) send(random_item());
  endtask

  initial begin
    drive_item_t it;
    board.load_defaults();
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // reset values: field extremes, voltage knee, nonpositive budget
    send(uniform(0, 0, 0, 0));
    send(uniform(0, 0, 0, 2));
    send(uniform(0, 0, 0, 1));
    send(uniform(16384, 16383, 3000, 1023));
    send(uniform(-16384, -16384, 3000, 1023));
    send(uniform(16384, -16384, 500, 1023));
    send(uniform(-16384, 16383, 501, 1023));
    send(uniform(100, 100, 500, 80));
    send(uniform(100, 100, 501, 80));
    send(uniform(-1, 1, 1500, 40));
    it = uniform(16384, 16383, 2048, 512);
    it.cur[1] = -16384; it.spd[2] = -16384; it.cur[3] = 21; it.spd[0] = 1;
    send(it);
    send(uniform(4000, -3000, 4095 & 3000, 200));
    drain();

    // ratio exactly one: 80*static = budget*17*2^12 with budget 1010
    write_all(0, 0, 0, 879104, 100);
    send(uniform(0, 0, 505, 0));
    send(uniform(0, 0, 506, 0));
    send(uniform(0, 0, 504, 0));
    drain();

    // zero estimate, and a margin above one
    write_all(0, 0, 0, 0, 65535);
    send(uniform(0, 0, 1000, 10));
    send(uniform(16384, 16383, 0, 2));
    send(uniform(-16384, -16384, 0, 1));
    drain();

    write_all(65535, 65535, 65535, 24'hFFFFFF, 65535);
    send(uniform(16384, 16383, 3000, 1023));
    send(uniform(1, 1, 3000, 1023));
    random_run(150);
    drain();

    write_all(TORQUE_RST, SPEED_SQ_RST, CURR_SQ_RST, STATIC_RST, MARGIN_RST);
    fork
      random_run(220);
      begin
        repeat (20) @(posedge clk);
        hold_req = 1;
      end
    join
    drain();

    write_all($urandom_range(65535), $urandom_range(20000), $urandom_range(5000),
              $urandom_range(24'hFFFFFF), $urandom_range(32768));
    calm = 1;
    random_run(220);
    calm = 0;
    drain();

    write_all(0, 0, 0, 0, 0);
    random_run(100);
    drain();

    write_all($urandom_range(20000), $urandom_range(6000), $urandom_range(2000),
              $urandom_range(600000), $urandom_range(300));
    random_run(180);
    drain();

    write_all($urandom_range(65535), $urandom_range(65535), $urandom_range(65535),
              $urandom_range(24'hFFFFFF), 32768);
    random_run(180);
    drain();

    if (board.errors == 0) begin
      $display("motor_power_limit_scale_test: PASS");
    end else begin
      $display("motor_power_limit_scale_test: FAIL");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/mpls_pkg.sv
hw/rtl/motor_power_limit_scale.sv
tb/motor_power_limit_scale_test.sv
